@@ hdl/sequence_item_support_filter_assert.svh @@
// Assertion macros for the item support filter.
// SISF_ASSERT_IMPL checks a same-cycle implication, SISF_ASSERT_NEXT a
// next-cycle implication. Both are disabled while reset is high.
`ifndef SEQUENCE_ITEM_SUPPORT_FILTER_ASSERT_SVH
`define SEQUENCE_ITEM_SUPPORT_FILTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SISF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sisf assertion failed");
`define SISF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sisf assertion failed");
`else
`define SISF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SISF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hdl/sisf_pkg.sv @@
package sisf_pkg;

  localparam int ITEM_COUNT  = 65536;
  localparam int COUNT_BITS  = 24;
  localparam int ADDR_W      = $clog2(ITEM_COUNT);
  localparam int ITEM_BITS   = 16;
  localparam int TAG_BITS    = 24;
  localparam int TOTAL_BITS  = 17;
  localparam int MINSUP_BITS = 24;
  localparam int ENTRY_W     = TAG_BITS + COUNT_BITS;
  localparam int RES_SLOTS   = 3;

  localparam logic OP_COUNT  = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  localparam logic [ENTRY_W-1:0]    CLEAR_WORD = {{TAG_BITS{1'b1}}, {COUNT_BITS{1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX  = {TOTAL_BITS{1'b1}};
  localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(ITEM_COUNT - 1);

  typedef struct packed {
    logic [ITEM_BITS-1:0] item;
    logic                 sep;
    logic                 last;
    logic                 empty;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_we;
    logic load;
    logic exec;
    logic emit_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       clear_last;
    logic       has_results;
    logic       emit_last;
    logic [1:0] res_count;
  } dp_stat_t;

endpackage

@@ hdl/sequence_item_support_filter.sv @@
// Sequence item support filter. Tokens arrive one per transfer on the input
// channel (valid/stall). operation 0 tokens run the count pass: each item's
// support rises at most once per sequence (a per-item tag holds the last
// sequence number seen), saturates at all ones, and a running number of
// items with support in 1..threshold is kept. operation 1 tokens run the
// filter pass: items with 0 < support <= threshold are dropped, separator
// runs collapse, leading and trailing separators go away, one kept item is
// held back so the sequence's final result carries last_of_sequence, and a
// sequence that keeps nothing yields a single empty_sequence result.
// Timing: after reset the block clears the support/tag memory, one entry
// per cycle, with stall high; config writes are still taken. Then every
// token goes through transfer, memory read and update (the support memory
// read is registered), and its results (0 to 3, filter pass only) are sent
// one per cycle while result_stall is low. The threshold (config_data)
// may be written whenever no token is in flight; config_ready is always
// high. infrequent_items shows the current running count with every result.
module sequence_item_support_filter (
  input  logic                                clk,
  input  logic                                rst,
  // token input
  input  logic                                valid,
  output logic                                stall,
  input  logic                                operation,
  input  logic [sisf_pkg::ITEM_BITS-1:0]      item,
  input  logic                                is_separator,
  input  logic                                last_in_sequence,
  // results
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [sisf_pkg::ITEM_BITS-1:0]      out_item,
  output logic                                out_separator,
  output logic                                last_of_sequence,
  output logic                                empty_sequence,
  output logic [sisf_pkg::TOTAL_BITS-1:0]     infrequent_items,
  // threshold register
  input  logic                                config_valid,
  output logic                                config_ready,
  input  logic [sisf_pkg::MINSUP_BITS-1:0]    config_data
);

  sisf_pkg::dp_cmd_t  cmd;
  sisf_pkg::dp_stat_t stat;
  sisf_pkg::res_t     res;

  // Threshold writes are plain register loads, always accepted.
  assign config_ready = 1'b1;

  sisf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .stall        (stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  sisf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (config_valid && config_ready),
    .cfg_data  (config_data),
    .in_op     (operation),
    .in_item   (item),
    .in_sep    (is_separator),
    .in_last   (last_in_sequence),
    .res_out   (res),
    .total_out (infrequent_items)
  );

  assign out_item         = res.item;
  assign out_separator    = res.sep;
  assign last_of_sequence = res.last;
  assign empty_sequence   = res.empty;

endmodule

@@ hdl/sisf_ram.sv @@
module sisf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sisf_datapath.sv @@
module sisf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  sisf_pkg::dp_cmd_t                   cmd,
  output sisf_pkg::dp_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [sisf_pkg::MINSUP_BITS-1:0]    cfg_data,
  input  logic                                in_op,
  input  logic [sisf_pkg::ITEM_BITS-1:0]      in_item,
  input  logic                                in_sep,
  input  logic                                in_last,
  output sisf_pkg::res_t                      res_out,
  output logic [sisf_pkg::TOTAL_BITS-1:0]     total_out
);

  // token register
  logic                             tok_op;
  logic [sisf_pkg::ITEM_BITS-1:0]   tok_item;
  logic                             tok_sep;
  logic                             tok_last;

  logic [sisf_pkg::MINSUP_BITS-1:0] support_limit;
  logic [sisf_pkg::TAG_BITS-1:0]    seq_num;
  logic [sisf_pkg::TOTAL_BITS-1:0]  total;
  logic [sisf_pkg::TOTAL_BITS-1:0]  total_next;
  logic [sisf_pkg::ADDR_W-1:0]      clear_addr;

  logic [sisf_pkg::ITEM_BITS-1:0]   held_item;
  logic                             held_valid;
  logic                             sep_pending;
  logic                             emitted_any;
  logic [sisf_pkg::ITEM_BITS-1:0]   held_item_next;
  logic                             held_valid_next;
  logic                             sep_pending_next;
  logic                             emitted_any_next;

  sisf_pkg::res_t                   res      [sisf_pkg::RES_SLOTS];
  sisf_pkg::res_t                   res_next [sisf_pkg::RES_SLOTS];
  logic [1:0]                       res_count;
  logic [1:0]                       res_count_next;
  logic [1:0]                       emit_idx;

  // memory
  logic                             ram_we;
  logic [sisf_pkg::ADDR_W-1:0]      ram_waddr;
  logic [sisf_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [sisf_pkg::ADDR_W-1:0]      tok_addr;
  logic [sisf_pkg::ENTRY_W-1:0]     ram_rdata;

  logic                             in_range;
  logic [sisf_pkg::COUNT_BITS-1:0]  cnt;
  logic [sisf_pkg::TAG_BITS-1:0]    tag;
  logic [sisf_pkg::COUNT_BITS-1:0]  cnt_inc;
  logic [sisf_pkg::COUNT_BITS-1:0]  cnt_eff;
  logic                             was_band;
  logic                             now_band;
  logic                             count_upd;
  logic                             keep;

  assign tok_addr = sisf_pkg::ADDR_W'(tok_item);
  assign in_range = 32'(tok_item) < 32'(sisf_pkg::ITEM_COUNT);
  assign cnt      = ram_rdata[sisf_pkg::COUNT_BITS-1:0];
  assign tag      = ram_rdata[sisf_pkg::ENTRY_W-1 -: sisf_pkg::TAG_BITS];
  assign cnt_inc  = cnt + sisf_pkg::COUNT_BITS'(1);

  // count pass
  assign count_upd = !tok_sep && in_range && (tag != seq_num);
  assign was_band  = (cnt != '0) && (32'(cnt) <= 32'(support_limit));
  assign now_band  = 32'(cnt_inc) <= 32'(support_limit);

  always_comb begin
    total_next = total;
    if (count_upd && cnt != sisf_pkg::COUNT_MAX) begin
      if (now_band && !was_band && total != sisf_pkg::TOTAL_MAX) begin
        total_next = total + sisf_pkg::TOTAL_BITS'(1);
      end else if (was_band && !now_band && total != '0) begin
        total_next = total - sisf_pkg::TOTAL_BITS'(1);
      end
    end
  end

  // filter pass; out-of-range items read as support 0
  assign cnt_eff = in_range ? cnt : '0;
  assign keep    = !((cnt_eff != '0) && (32'(cnt_eff) <= 32'(support_limit)));

  always_comb begin
    held_item_next   = held_item;
    held_valid_next  = held_valid;
    sep_pending_next = sep_pending;
    emitted_any_next = emitted_any;
    res_count_next   = '0;
    for (int i = 0; i < sisf_pkg::RES_SLOTS; i++) begin
      res_next[i] = '0;
    end

    if (tok_sep) begin
      if (emitted_any) begin
        sep_pending_next = 1'b1;
      end
    end else if (keep) begin
      if (held_valid) begin
        res_next[res_count_next].item = held_item;
        res_count_next = res_count_next + 2'd1;
        if (sep_pending) begin
          res_next[res_count_next].sep = 1'b1;
          res_count_next = res_count_next + 2'd1;
        end
      end
      sep_pending_next = 1'b0;
      held_item_next   = tok_item;
      held_valid_next  = 1'b1;
      emitted_any_next = 1'b1;
    end

    if (tok_last) begin
      res_next[res_count_next].last = 1'b1;
      if (held_valid_next) begin
        res_next[res_count_next].item = held_item_next;
      end else begin
        res_next[res_count_next].empty = 1'b1;
      end
      res_count_next   = res_count_next + 2'd1;
      held_item_next   = '0;
      held_valid_next  = 1'b0;
      sep_pending_next = 1'b0;
      emitted_any_next = 1'b0;
    end
  end

  // memory write: clearing pass or count update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tok_addr;
    ram_wdata = {seq_num, (cnt == sisf_pkg::COUNT_MAX) ? cnt : cnt_inc};
    if (cmd.clear_we) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = sisf_pkg::CLEAR_WORD;
    end else if (cmd.exec && tok_op == sisf_pkg::OP_COUNT && count_upd) begin
      ram_we = 1'b1;
    end
  end

  sisf_ram #(
    .WIDTH (sisf_pkg::ENTRY_W),
    .DEPTH (sisf_pkg::ITEM_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (tok_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok_op   <= in_op;
      tok_item <= in_item;
      tok_sep  <= in_sep;
      tok_last <= in_last;
    end
    if (cmd.exec && tok_op == sisf_pkg::OP_FILTER) begin
      held_item <= held_item_next;
      for (int i = 0; i < sisf_pkg::RES_SLOTS; i++) begin
        res[i] <= res_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      support_limit <= '0;
      seq_num       <= '0;
      total         <= '0;
      clear_addr    <= '0;
      held_valid    <= 1'b0;
      sep_pending   <= 1'b0;
      emitted_any   <= 1'b0;
      res_count     <= '0;
      emit_idx      <= '0;
    end else begin
      if (cfg_we) begin
        support_limit <= cfg_data;
      end
      if (cmd.clear_we) begin
        clear_addr <= clear_addr + sisf_pkg::ADDR_W'(1);
      end
      if (cmd.exec) begin
        emit_idx <= '0;
        if (tok_op == sisf_pkg::OP_COUNT) begin
          total     <= total_next;
          res_count <= '0;
          if (tok_last) begin
            seq_num <= seq_num + sisf_pkg::TAG_BITS'(1);
          end
        end else begin
          held_valid  <= held_valid_next;
          sep_pending <= sep_pending_next;
          emitted_any <= emitted_any_next;
          res_count   <= res_count_next;
        end
      end else if (cmd.emit_step) begin
        emit_idx <= emit_idx + 2'd1;
      end
    end
  end

  assign stat.clear_last  = clear_addr == sisf_pkg::LAST_ADDR;
  assign stat.has_results = (tok_op == sisf_pkg::OP_FILTER) && (res_count_next != '0);
  assign stat.emit_last   = emit_idx == (res_count - 2'd1);
  assign stat.res_count   = res_count;

  assign res_out   = res[emit_idx];
  assign total_out = total;

endmodule

@@ hdl/sisf_ctrl.sv @@
`include "sequence_item_support_filter_assert.svh"

module sisf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  output logic                result_valid,
  input  logic                result_stall,
  output sisf_pkg::dp_cmd_t   cmd,
  input  sisf_pkg::dp_stat_t  stat
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = stat.has_results ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!result_stall && stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign stall         = state != ST_IDLE;
  assign result_valid  = state == ST_EMIT;
  assign cmd.clear_we  = state == ST_CLEAR;
  assign cmd.load      = (state == ST_IDLE) && valid;
  assign cmd.exec      = state == ST_EXEC;
  assign cmd.emit_step = (state == ST_EMIT) && !result_stall;

  `SISF_ASSERT_IMPL(a_emit_has_data, clk, rst, state == ST_EMIT, stat.res_count != 2'd0)
  `SISF_ASSERT_IMPL(a_exec_after_look, clk, rst, state == ST_EXEC, $past(state) == ST_LOOK)
  `SISF_ASSERT_NEXT(a_accept_to_look, clk, rst, cmd.load, state == ST_LOOK)
  `SISF_ASSERT_NEXT(a_last_result_done, clk, rst, cmd.emit_step && stat.emit_last,
                    state == ST_IDLE)

endmodule
